>>> rtl/cdg_pkg.sv
`default_nettype none

package cdg_pkg;

    localparam int MAX_WIDTH_DEF    = 4096;
    localparam int PIXEL_BITS_DEF   = 16;

    localparam int GRAD_BITS        = 17;
    localparam int COL_BITS         = 12;
    localparam int ROW_BITS         = 16;
    localparam int CFG_DATA_BITS    = 16;
    localparam int WIDTH_FIELD_BITS = 13;
    localparam int GRAD_LIM         = 65535;
    localparam int MIN_DIM          = 3;
    localparam int WIDTH_RESET      = 640;
    localparam int HEIGHT_RESET     = 480;

    localparam int MAX_RESULTS      = 3;
    localparam int QUEUE_DEPTH      = 8;
    localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                valid;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        logic                has_above;
        logic                has_two_above;
        logic                has_left;
        logic                has_left2;
        logic                interior_x;
        logic                last_row;
        logic                last_col;
    } stage_t;

    typedef struct packed {
        logic signed [GRAD_BITS-1:0] grad_x;
        logic signed [GRAD_BITS-1:0] grad_y;
        logic [COL_BITS-1:0]         col;
        logic [ROW_BITS-1:0]         row;
        logic                        last_of_run;
        logic                        end_of_frame;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/cdg_line_store.sv
`default_nettype none

module cdg_line_store #(
    parameter int DEPTH     = 4096,
    parameter int DATA_BITS = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_BITS-1:0]     wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_BITS-1:0]     rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/cdg_ctrl.sv
`default_nettype none

module cdg_ctrl #(
    parameter int MAX_WIDTH  = cdg_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = cdg_pkg::PIXEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  cdg_pkg::cfg_reg_t                   cfg_index,
    input  logic [cdg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                accept,
    input  logic signed [PIXEL_BITS-1:0]        pixel,
    output cdg_pkg::stage_t                     s1,
    output logic [$clog2(MAX_WIDTH)-1:0]        s1_addr,
    output logic signed [PIXEL_BITS-1:0]        s1_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]        rd_addr
);

    import cdg_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [WW-1:0]       width_reg;
    logic [ROW_BITS-1:0] height_reg;
    logic [AW-1:0]       col_reg;
    logic [AW-1:0]       col_next;
    logic [ROW_BITS-1:0] row_reg;
    logic [ROW_BITS-1:0] row_next;
    stage_t              s1_reg;
    stage_t              s1_next;
    logic [AW-1:0]       s1_addr_reg;
    logic signed [PIXEL_BITS-1:0] s1_pixel_reg;

    logic [WIDTH_FIELD_BITS-1:0] width_field;
    logic [WW-1:0]               width_cfg;
    logic [ROW_BITS-1:0]         height_cfg;
    logic [WW-1:0]               col_inc;
    logic [ROW_BITS-1:0]         row_inc;
    logic                        last_col;
    logic                        last_row;

    assign width_field = cfg_data[WIDTH_FIELD_BITS-1:0];

    always_comb
    begin
        priority if (32'(width_field) < 32'(MIN_DIM))
        begin
            width_cfg = WW'(MIN_DIM);
        end
        else if (32'(width_field) > 32'(MAX_WIDTH))
        begin
            width_cfg = WW'(MAX_WIDTH);
        end
        else
        begin
            width_cfg = WW'(width_field);
        end
    end

    always_comb
    begin
        if (cfg_data[ROW_BITS-1:0] < ROW_BITS'(MIN_DIM))
        begin
            height_cfg = ROW_BITS'(MIN_DIM);
        end
        else
        begin
            height_cfg = cfg_data[ROW_BITS-1:0];
        end
    end

    assign col_inc  = WW'(col_reg) + WW'(1);
    assign row_inc  = row_reg + ROW_BITS'(1);
    assign last_col = (col_inc == width_reg);
    assign last_row = (row_inc == height_reg);
    assign rd_addr  = last_col ? '0 : AW'(col_inc);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc;
            end
            else
            begin
                col_next = AW'(col_inc);
            end
        end
    end

    always_comb
    begin
        s1_next.valid         = accept;
        s1_next.col           = COL_BITS'(col_reg);
        s1_next.row           = row_reg;
        s1_next.has_above     = (row_reg != '0);
        s1_next.has_two_above = (row_reg > ROW_BITS'(1));
        s1_next.has_left      = (col_reg != '0);
        s1_next.has_left2     = (col_reg > AW'(1));
        s1_next.interior_x    = (col_reg != '0) && !last_col;
        s1_next.last_row      = last_row;
        s1_next.last_col      = last_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(WIDTH_RESET);
            height_reg <= ROW_BITS'(HEIGHT_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
            s1_reg     <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= width_cfg;
                    REG_FRAME_HEIGHT: height_reg <= height_cfg;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            else
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg  <= col_reg;
            s1_pixel_reg <= pixel;
        end
    end

    assign s1       = s1_reg;
    assign s1_addr  = s1_addr_reg;
    assign s1_pixel = s1_pixel_reg;

endmodule

`default_nettype wire

>>> rtl/cdg_grad_core.sv
`default_nettype none

module cdg_grad_core #(
    parameter int PIXEL_BITS = cdg_pkg::PIXEL_BITS_DEF
) (
    input  logic                                       clk,
    input  cdg_pkg::stage_t                            s1,
    input  logic signed [PIXEL_BITS-1:0]               s1_pixel,
    input  logic signed [PIXEL_BITS-1:0]               q_above,
    input  logic signed [PIXEL_BITS-1:0]               q_two_above,
    output logic signed [PIXEL_BITS-1:0]               wr_two_above,
    output cdg_pkg::result_t [cdg_pkg::MAX_RESULTS-1:0] results,
    output logic [1:0]                                 push_n
);

    import cdg_pkg::*;

    localparam int DW = PIXEL_BITS + 1;
    localparam int EW = (DW > GRAD_BITS) ? DW : GRAD_BITS;
    localparam logic signed [EW-1:0] LIM_P = EW'(GRAD_LIM);
    localparam logic signed [EW-1:0] LIM_N = -LIM_P;

    logic signed [PIXEL_BITS-1:0] cur_a_reg;
    logic signed [PIXEL_BITS-1:0] cur_b_reg;
    logic signed [PIXEL_BITS-1:0] left_a_reg;
    logic signed [PIXEL_BITS-1:0] prev_reg;
    logic signed [PIXEL_BITS-1:0] prev_prev_reg;

    logic v_above;
    logic v_left;
    logic v_own;

    function automatic logic signed [GRAD_BITS-1:0] sat_diff(
        input logic signed [PIXEL_BITS-1:0] a,
        input logic signed [PIXEL_BITS-1:0] b
    );
        logic signed [EW-1:0] d;
        d = EW'(a) - EW'(b);
        if (d > LIM_P)
        begin
            d = LIM_P;
        end
        else if (d < LIM_N)
        begin
            d = LIM_N;
        end
        return d[GRAD_BITS-1:0];
    endfunction

    assign v_above = s1.valid && s1.has_above;
    assign v_left  = s1.valid && s1.last_row && s1.has_left;
    assign v_own   = s1.valid && s1.last_row && s1.last_col;
    assign push_n  = {1'b0, v_above} + {1'b0, v_left} + {1'b0, v_own};

    always_comb
    begin
        results[0].grad_x       = s1.interior_x ? sat_diff(q_above, left_a_reg) : '0;
        results[0].grad_y       = s1.has_two_above ? sat_diff(s1_pixel, cur_b_reg) : '0;
        results[0].col          = s1.col;
        results[0].row          = s1.row - ROW_BITS'(1);
        results[0].last_of_run  = !v_left;
        results[0].end_of_frame = 1'b0;

        results[1].grad_x       = s1.has_left2 ? sat_diff(s1_pixel, prev_prev_reg) : '0;
        results[1].grad_y       = '0;
        results[1].col          = s1.col - COL_BITS'(1);
        results[1].row          = s1.row;
        results[1].last_of_run  = !v_own;
        results[1].end_of_frame = 1'b0;

        results[2].grad_x       = '0;
        results[2].grad_y       = '0;
        results[2].col          = s1.col;
        results[2].row          = s1.row;
        results[2].last_of_run  = 1'b1;
        results[2].end_of_frame = 1'b1;
    end

    // advance the column window and the in-row history
    always_ff @(posedge clk)
    begin
        if (s1.valid)
        begin
            cur_a_reg     <= q_above;
            cur_b_reg     <= q_two_above;
            left_a_reg    <= cur_a_reg;
            prev_reg      <= s1_pixel;
            prev_prev_reg <= prev_reg;
        end
    end

    assign wr_two_above = cur_a_reg;

endmodule

`default_nettype wire

>>> rtl/cdg_out_queue.sv
`default_nettype none

module cdg_out_queue (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic [1:0]                                  push_n,
    input  cdg_pkg::result_t [cdg_pkg::MAX_RESULTS-1:0] results,
    input  logic                                        out_ready,
    output logic                                        out_valid,
    output cdg_pkg::result_t                            head,
    output logic [cdg_pkg::QUEUE_CNT_BITS-1:0]          count,
    output logic                                        room
);

    import cdg_pkg::*;

    result_t                   buf_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] head_reg;
    logic [QUEUE_PTR_BITS-1:0] tail_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;
    logic                      pop;

    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && out_ready;
    assign count_next = count_reg + QUEUE_CNT_BITS'(push_n) - QUEUE_CNT_BITS'(pop);
    assign room       = (count_reg + QUEUE_CNT_BITS'(push_n))
                        <= QUEUE_CNT_BITS'(QUEUE_DEPTH - MAX_RESULTS);
    assign head       = buf_reg[head_reg];
    assign count      = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_reg + QUEUE_PTR_BITS'(pop);
            tail_reg  <= tail_reg + QUEUE_PTR_BITS'(push_n);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (2'(i) < push_n)
            begin
                buf_reg[tail_reg + QUEUE_PTR_BITS'(i)] <= results[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/central_difference_gradient.sv
`default_nettype none

// Streaming central-difference gradient over a raster-order frame of
// frame_width x frame_height pixels. One pixel word is taken per clock while
// in_ready is high; each pixel writes one line-store entry and reads the
// entry one column ahead, so the single dual-ported line store sets that
// rate. A pixel's result leaves once the pixel below it arrives and passes
// the stage register and the result queue. Results drain one word per clock
// while out_ready is high from an eight-entry result queue; in the last row
// each pixel but the first yields two result words (three for the final
// pixel), so there input waits for queue room. Both line stores share one
// memory of MAX_WIDTH entries that holds no reset contents and needs no
// clearing. A configuration write restarts the frame at row 0, column 0.

module central_difference_gradient #(
    parameter int MAX_WIDTH  = cdg_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = cdg_pkg::PIXEL_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  cdg_pkg::cfg_reg_t                     cfg_index,
    input  logic [cdg_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [PIXEL_BITS-1:0]          pixel,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [cdg_pkg::GRAD_BITS-1:0]  grad_x,
    output logic signed [cdg_pkg::GRAD_BITS-1:0]  grad_y,
    output logic [cdg_pkg::COL_BITS-1:0]          out_col,
    output logic [cdg_pkg::ROW_BITS-1:0]          out_row,
    output logic                                  last_of_run,
    output logic                                  end_of_frame
);

    import cdg_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic                         accept;
    stage_t                       s1;
    logic [AW-1:0]                s1_addr;
    logic signed [PIXEL_BITS-1:0] s1_pixel;
    logic [AW-1:0]                rd_addr;
    logic [2*PIXEL_BITS-1:0]      rd_data;
    logic signed [PIXEL_BITS-1:0] q_above;
    logic signed [PIXEL_BITS-1:0] q_two_above;
    logic signed [PIXEL_BITS-1:0] wr_two_above;
    result_t [MAX_RESULTS-1:0]    results;
    logic [1:0]                   push_n;
    result_t                      head;
    logic [QUEUE_CNT_BITS-1:0]    q_count;
    logic                         room;

    assign accept = in_valid && in_ready;

    cdg_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pixel     (pixel),
        .s1        (s1),
        .s1_addr   (s1_addr),
        .s1_pixel  (s1_pixel),
        .rd_addr   (rd_addr)
    );

    cdg_line_store #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (2 * PIXEL_BITS)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1.valid),
        .wr_addr (s1_addr),
        .wr_data ({s1_pixel, wr_two_above}),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign q_above     = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign q_two_above = rd_data[PIXEL_BITS-1:0];

    cdg_grad_core #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_core (
        .clk          (clk),
        .s1           (s1),
        .s1_pixel     (s1_pixel),
        .q_above      (q_above),
        .q_two_above  (q_two_above),
        .wr_two_above (wr_two_above),
        .results      (results),
        .push_n       (push_n)
    );

    cdg_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .results   (results),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .count     (q_count),
        .room      (room)
    );

    assign in_ready     = room;
    assign grad_x       = head.grad_x;
    assign grad_y       = head.grad_y;
    assign out_col      = head.col;
    assign out_row      = head.row;
    assign last_of_run  = head.last_of_run;
    assign end_of_frame = head.end_of_frame;

    a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1.valid)
        else $error("accepted word did not reach the gradient stage");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_frame_end_burst: assert property (@(posedge clk) disable iff (!rst_n)
        s1.valid && s1.last_row && s1.last_col |-> push_n == 2'd3)
        else $error("final pixel must release three results");

    a_eof_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> last_of_run)
        else $error("end of frame result is not last of its run");

endmodule

`default_nettype wire
